FILE: hw/rtl/wacs_pkg.sv
// Shared widths, codes, configuration type and scoring constants of the comfort scorer.
package wacs_pkg;

    localparam int TEMP_W     = 15;
    localparam int HUM_W      = 14;
    localparam int PRES_W     = 17;
    localparam int SAMPLE_W   = TEMP_W + HUM_W + PRES_W;
    localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    localparam int INDEX_W      = 14;
    localparam int LEVEL_W      = 2;
    localparam int OUT_FIELDS_W = INDEX_W + LEVEL_W + TEMP_W + HUM_W + PRES_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMPERATURE_TARGET = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_HUMIDITY_TARGET    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_TARGET    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_GOOD_THRESHOLD     = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_MODERATE_THRESHOLD = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_POOR_THRESHOLD     = CFG_INDEX_W'(5);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_target;
        logic [HUM_W-1:0]         humidity_target;
        logic [PRES_W-1:0]        pressure_target;
        logic [INDEX_W-1:0]       good_threshold;
        logic [INDEX_W-1:0]       moderate_threshold;
        logic [INDEX_W-1:0]       poor_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        temperature_target: TEMP_W'(2200),
        humidity_target:    HUM_W'(5000),
        pressure_target:    PRES_W'(101325),
        good_threshold:     INDEX_W'(8000),
        moderate_threshold: INDEX_W'(6000),
        poor_threshold:     INDEX_W'(4000)
    };

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_GOOD     = 2'd0,
        LEVEL_MODERATE = 2'd1,
        LEVEL_POOR     = 2'd2,
        LEVEL_CRITICAL = 2'd3
    } level_t;

    // Fewest samples in the window that give a result.
    localparam int MIN_FILL = 3;

    // Score = 1000000 - (200*dT + 60*dH + 2*dP), in millionths of the full score.
    localparam int PENALTY_W   = 23;
    localparam int WPOS_W      = 20;
    localparam int SCORE_BASE  = 1000000;
    localparam int TEMP_WEIGHT = 200;
    localparam int HUM_WEIGHT  = 60;
    localparam int PRES_WEIGHT = 2;

    // floor(x / 100) = (x * DIV100_RECIP) >> DIV100_SHIFT, exact for x below 1.8e6.
    localparam int RECIP_W      = 21;
    localparam int DIV100_SHIFT = 27;
    localparam int DIV100_RECIP = 1342178;
    localparam int PROD_W       = WPOS_W + RECIP_W;

endpackage

FILE: hw/rtl/window_average_comfort_scorer.sv
// Windowed comfort scorer: averages the last WINDOW_DEPTH samples and grades them against targets.
// Each accepted sample enters a window of the last WINDOW_DEPTH samples; once three or more
// are held, one result word follows with the truncated window averages, a comfort index of
// 0..10000 and an alert level. The front takes no new sample while it updates the sums or
// waits for room to queue a result, and hands the sums to a two-entry queue; the back then
// forms the three averages one after another with one serial divider, one quotient bit per
// cycle, and holds each result until the output is free. Configuration writes take effect at
// once and are meant for idle periods.
module window_average_comfort_scorer
    import wacs_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // temperature[14:0], humidity[28:15], pressure[45:29], zero fill
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // score[13:0], level[15:14], average_temperature[30:16],
    // average_humidity[44:31], average_pressure[61:45], zero fill
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int JOB_W  = TEMP_W + HUM_W + PRES_W + 3 * SLOT_W + CNT_W;

    cfg_t             cfg_reg;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [JOB_W-1:0] push_job;
    logic [JOB_W-1:0] pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMPERATURE_TARGET: cfg_reg.temperature_target <= cfg_data[TEMP_W-1:0];
                CFG_HUMIDITY_TARGET:    cfg_reg.humidity_target    <= cfg_data[HUM_W-1:0];
                CFG_PRESSURE_TARGET:    cfg_reg.pressure_target    <= cfg_data[PRES_W-1:0];
                CFG_GOOD_THRESHOLD:     cfg_reg.good_threshold     <= cfg_data[INDEX_W-1:0];
                CFG_MODERATE_THRESHOLD: cfg_reg.moderate_threshold <= cfg_data[INDEX_W-1:0];
                CFG_POOR_THRESHOLD:     cfg_reg.poor_threshold     <= cfg_data[INDEX_W-1:0];
                default: ;
            endcase
        end
    end

    wacs_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[SAMPLE_W-1:0]),
        .push     (push),
        .job      (push_job),
        .full     (full)
    );

    wacs_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .full      (full),
        .empty     (empty)
    );

    wacs_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (!empty),
        .job       (pop_job),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: hw/rtl/wacs_fifo.sv
// Two-entry queue of window sums between the front and the back of the scorer.
module wacs_fifo
    import wacs_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");

endmodule

FILE: hw/rtl/wacs_front.sv
// Sample window: stores samples, keeps running sums and queues a job per scored sample.
module wacs_front
    import wacs_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [SAMPLE_W-1:0]                     sample,
    output logic                                    push,
    output logic [PRES_W+HUM_W+TEMP_W+3*$clog2(WINDOW_DEPTH)
                  +$clog2(WINDOW_DEPTH+1)-1:0]      job,
    input  logic                                    full
);

    localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int T_SUM_W   = TEMP_W + SLOT_W;
    localparam int H_SUM_W   = HUM_W + SLOT_W;
    localparam int P_SUM_W   = PRES_W + SLOT_W;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_UPDATE = 3'b010,
        F_PUSH   = 3'b100
    } front_state_t;

    front_state_t               state_reg, state_next;
    logic [SLOT_W-1:0]          slot_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic                       was_full_reg;
    logic signed [T_SUM_W-1:0]  t_sum_reg;
    logic [H_SUM_W-1:0]         h_sum_reg;
    logic [P_SUM_W-1:0]         p_sum_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        old_reg;
    logic [SAMPLE_W-1:0]        store [WINDOW_DEPTH];

    logic                       accept;
    logic signed [TEMP_W-1:0]   new_t, old_t;
    logic [HUM_W-1:0]           new_h, old_h;
    logic [PRES_W-1:0]          new_p, old_p;

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == F_PUSH) && !full;
    assign job      = {fill_reg, p_sum_reg, h_sum_reg, t_sum_reg};

    assign new_t = sample_reg[TEMP_W-1:0];
    assign new_h = sample_reg[TEMP_W +: HUM_W];
    assign new_p = sample_reg[TEMP_W+HUM_W +: PRES_W];
    assign old_t = old_reg[TEMP_W-1:0];
    assign old_h = old_reg[TEMP_W +: HUM_W];
    assign old_p = old_reg[TEMP_W+HUM_W +: PRES_W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
                if (accept)
                    state_next = F_UPDATE;
            F_UPDATE:
                if (fill_reg >= CNT_W'(MIN_FILL))
                    state_next = F_PUSH;
                else
                    state_next = F_IDLE;
            F_PUSH:
                if (!full)
                    state_next = F_IDLE;
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            slot_reg     <= '0;
            fill_reg     <= '0;
            was_full_reg <= 1'b0;
            t_sum_reg    <= '0;
            h_sum_reg    <= '0;
            p_sum_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                // The write slot is always the oldest entry once the window is full.
                slot_reg     <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                was_full_reg <= (fill_reg == CNT_W'(WINDOW_DEPTH));
                if (fill_reg != CNT_W'(WINDOW_DEPTH))
                    fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == F_UPDATE)
            begin
                t_sum_reg <= t_sum_reg + T_SUM_W'(new_t)
                           - (was_full_reg ? T_SUM_W'(old_t) : T_SUM_W'(0));
                h_sum_reg <= h_sum_reg + H_SUM_W'(new_h)
                           - (was_full_reg ? H_SUM_W'(old_h) : H_SUM_W'(0));
                p_sum_reg <= p_sum_reg + P_SUM_W'(new_p)
                           - (was_full_reg ? P_SUM_W'(old_p) : P_SUM_W'(0));
            end
        end
    end

    // Read the departing entry before it is overwritten.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store[slot_reg] <= sample;
            old_reg         <= store[slot_reg];
            sample_reg      <= sample;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");
    a_push_filled: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> fill_reg >= CNT_W'(MIN_FILL))
        else $error("job queued with too few samples");

endmodule

FILE: hw/rtl/wacs_div.sv
// Restoring serial divider, one quotient bit per cycle.
module wacs_div
    import wacs_pkg::*;
#(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg, q_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign done      = done_reg;
    assign quo       = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/wacs_back.sv
// Scoring engine: averages via the serial divider, weighted index, level and output register.
module wacs_back
    import wacs_pkg::*;
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cfg_t                                    cfg,
    input  logic                                    job_valid,
    input  logic [PRES_W+HUM_W+TEMP_W+3*$clog2(WINDOW_DEPTH)
                  +$clog2(WINDOW_DEPTH+1)-1:0]      job,
    output logic                                    job_pop,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [OUT_DATA_W-1:0]                   m_tdata
);

    localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int T_SUM_W = TEMP_W + SLOT_W;
    localparam int H_SUM_W = HUM_W + SLOT_W;
    localparam int P_SUM_W = PRES_W + SLOT_W;
    localparam int JOB_W   = T_SUM_W + H_SUM_W + P_SUM_W + CNT_W;
    localparam int NUM_W   = P_SUM_W;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_DIV_T = 9'b000000010,
        B_DIV_H = 9'b000000100,
        B_DIV_P = 9'b000001000,
        B_DIST  = 9'b000010000,
        B_PEN   = 9'b000100000,
        B_WPOS  = 9'b001000000,
        B_MUL   = 9'b010000000,
        B_OUT   = 9'b100000000
    } back_state_t;

    back_state_t               state_reg, state_next;
    logic                      start_reg;
    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;
    logic [JOB_W-1:0]          job_reg;
    logic signed [TEMP_W-1:0]  at_reg;
    logic [HUM_W-1:0]          ah_reg;
    logic [PRES_W-1:0]         ap_reg;
    logic [TEMP_W-1:0]         dt_reg;
    logic [HUM_W-1:0]          dh_reg;
    logic [PRES_W-1:0]         dp_reg;
    logic [PENALTY_W-1:0]      pen_reg;
    logic [WPOS_W-1:0]         wpos_reg;
    logic [PROD_W-1:0]         prod_reg;

    logic [T_SUM_W-1:0]        t_sum;
    logic [H_SUM_W-1:0]        h_sum;
    logic [P_SUM_W-1:0]        p_sum;
    logic [CNT_W-1:0]          count;
    logic                      t_neg;
    logic [T_SUM_W-1:0]        t_mag;
    logic [NUM_W-1:0]          div_num;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [TEMP_W:0]           t_diff;
    logic [INDEX_W-1:0]        index;
    level_t                    level;
    logic                      out_free;

    assign t_sum = job_reg[T_SUM_W-1:0];
    assign h_sum = job_reg[T_SUM_W +: H_SUM_W];
    assign p_sum = job_reg[T_SUM_W+H_SUM_W +: P_SUM_W];
    assign count = job_reg[T_SUM_W+H_SUM_W+P_SUM_W +: CNT_W];
    assign t_neg = t_sum[T_SUM_W-1];
    assign t_mag = t_neg ? (~t_sum + 1'b1) : t_sum;

    always_comb
    begin
        div_num = NUM_W'(p_sum);
        priority case (1'b1)
            state_reg == B_DIV_T: div_num = NUM_W'(t_mag);
            state_reg == B_DIV_H: div_num = NUM_W'(h_sum);
            default:              div_num = NUM_W'(p_sum);
        endcase
    end

    wacs_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (div_num),
        .den   (count),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign t_diff   = {at_reg[TEMP_W-1], at_reg}
                    - {cfg.temperature_target[TEMP_W-1], cfg.temperature_target};
    assign index    = prod_reg[DIV100_SHIFT +: INDEX_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign job_pop  = (state_reg == B_IDLE) && job_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        priority if (index >= cfg.good_threshold)
            level = LEVEL_GOOD;
        else if (index >= cfg.moderate_threshold)
            level = LEVEL_MODERATE;
        else if (index >= cfg.poor_threshold)
            level = LEVEL_POOR;
        else
            level = LEVEL_CRITICAL;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_DIV_T;
            B_DIV_T: if (div_done)  state_next = B_DIV_H;
            B_DIV_H: if (div_done)  state_next = B_DIV_P;
            B_DIV_P: if (div_done)  state_next = B_DIST;
            B_DIST:  state_next = B_PEN;
            B_PEN:   state_next = B_WPOS;
            B_WPOS:  state_next = B_MUL;
            B_MUL:   state_next = B_OUT;
            B_OUT:   if (out_free)  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Kick the divider on entry to each division state.
            start_reg <= job_pop
                      || (div_done && (state_reg == B_DIV_T || state_reg == B_DIV_H));
            if (state_reg == B_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        if (div_done && state_reg == B_DIV_T)
            at_reg <= t_neg ? (~div_quo[TEMP_W-1:0] + 1'b1) : div_quo[TEMP_W-1:0];
        if (div_done && state_reg == B_DIV_H)
            ah_reg <= div_quo[HUM_W-1:0];
        if (div_done && state_reg == B_DIV_P)
            ap_reg <= div_quo[PRES_W-1:0];
        if (state_reg == B_DIST)
        begin
            dt_reg <= t_diff[TEMP_W] ? TEMP_W'(~t_diff + 1'b1) : t_diff[TEMP_W-1:0];
            dh_reg <= (ah_reg >= cfg.humidity_target) ? ah_reg - cfg.humidity_target
                                                      : cfg.humidity_target - ah_reg;
            dp_reg <= (ap_reg >= cfg.pressure_target) ? ap_reg - cfg.pressure_target
                                                      : cfg.pressure_target - ap_reg;
        end
        if (state_reg == B_PEN)
            pen_reg <= PENALTY_W'(dt_reg) * PENALTY_W'(TEMP_WEIGHT)
                     + PENALTY_W'(dh_reg) * PENALTY_W'(HUM_WEIGHT)
                     + PENALTY_W'(dp_reg) * PENALTY_W'(PRES_WEIGHT);
        // A negative weighted score floors at zero.
        if (state_reg == B_WPOS)
            wpos_reg <= (pen_reg >= PENALTY_W'(SCORE_BASE)) ? '0
                      : WPOS_W'(PENALTY_W'(SCORE_BASE) - pen_reg);
        if (state_reg == B_MUL)
            prod_reg <= PROD_W'(wpos_reg) * PROD_W'(DIV100_RECIP);
        if (state_reg == B_OUT && out_free)
            m_tdata_reg <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, ap_reg, ah_reg, at_reg,
                            level, index};
    end

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == B_DIV_T || state_reg == B_DIV_H || state_reg == B_DIV_P))
        else $error("divider finished outside a division state");
    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == B_OUT))
        else $error("result word raised without a finished score");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_OUT |-> index <= INDEX_W'(10000))
        else $error("comfort index beyond full scale");

endmodule

FILE: tb/sv/window_average_comfort_scorer_tb.sv
// Self-checking testbench for the windowed comfort scorer: directed plan, random phases, predictor.
module window_average_comfort_scorer_tb;
    import wacs_pkg::*;

    localparam int WINDOW_DEPTH    = 16;
    localparam int SETTLE_CYCLES   = 300;
    localparam int IDLE_LIMIT      = 3000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 142;

    localparam int LEVEL_LO = INDEX_W;
    localparam int AVG_T_LO = LEVEL_LO + LEVEL_W;
    localparam int AVG_H_LO = AVG_T_LO + TEMP_W;
    localparam int AVG_P_LO = AVG_H_LO + HUM_W;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_6 = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_7 = CFG_INDEX_W'(7);

    typedef struct {
        logic [INDEX_W-1:0] score;
        level_t             level;
        logic [TEMP_W-1:0]  average_temperature;
        logic [HUM_W-1:0]   average_humidity;
        logic [PRES_W-1:0]  average_pressure;
    } comfort_result_t;

    typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [TEMP_W-1:0]      temperature;
        logic [HUM_W-1:0]       humidity;
        logic [PRES_W-1:0]      pressure;
        bit                     typed;
        bit                     typed_gives;
        comfort_result_t        want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    window_average_comfort_scorer #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scorer copy: settings, sample window and running sums.
    cfg_t        settings = CFG_RESET;
    longint      temp_win [WINDOW_DEPTH];
    longint      hum_win  [WINDOW_DEPTH];
    longint      pres_win [WINDOW_DEPTH];
    longint      temp_total = 0;
    longint      hum_total  = 0;
    longint      pres_total = 0;
    int unsigned held = 0;
    int unsigned head = 0;

    comfort_result_t pending_results[$];
    plan_row_t       plan[$];

    int unsigned errors          = 0;
    int unsigned results_checked = 0;
    int unsigned samples_sent    = 0;
    int unsigned quiet_cycles    = 0;
    bit          no_gaps         = 1'b0;
    bit          dirty           = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint distance(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void apply_setting(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_TEMPERATURE_TARGET: settings.temperature_target = value[TEMP_W-1:0];
            CFG_HUMIDITY_TARGET:    settings.humidity_target    = value[HUM_W-1:0];
            CFG_PRESSURE_TARGET:    settings.pressure_target    = value[PRES_W-1:0];
            CFG_GOOD_THRESHOLD:     settings.good_threshold     = value[INDEX_W-1:0];
            CFG_MODERATE_THRESHOLD: settings.moderate_threshold = value[INDEX_W-1:0];
            CFG_POOR_THRESHOLD:     settings.poor_threshold     = value[INDEX_W-1:0];
            default: ;
        endcase
    endfunction

    // Insert one sample into the window; returns 1 when a result word follows.
    function automatic bit score_window(input logic [TEMP_W-1:0] t_raw,
                                        input logic [HUM_W-1:0] h_raw,
                                        input logic [PRES_W-1:0] p_raw,
                                        output comfort_result_t res);
        longint      t, h, p, n, at, ah, ap, w, ci;
        int unsigned slot;
        t = longint'($signed(t_raw));
        h = longint'(h_raw);
        p = longint'(p_raw);
        if (held < WINDOW_DEPTH)
        begin
            slot = (head + held) % WINDOW_DEPTH;
            held++;
        end
        else
        begin
            // Full window: drop the oldest sample from the sums.
            slot = head;
            temp_total -= temp_win[slot];
            hum_total  -= hum_win[slot];
            pres_total -= pres_win[slot];
            head = (slot + 1) % WINDOW_DEPTH;
        end
        temp_win[slot] = t;
        hum_win[slot]  = h;
        pres_win[slot] = p;
        temp_total += t;
        hum_total  += h;
        pres_total += p;
        if (held < MIN_FILL)
            return 1'b0;
        n  = longint'(held);
        at = temp_total / n;
        ah = hum_total / n;
        ap = pres_total / n;
        w = 5 * (100000 - 40 * distance(at, longint'($signed(settings.temperature_target))))
          + 3 * (100000 - 20 * distance(ah, longint'(settings.humidity_target)))
          + 2 * (100000 - distance(ap, longint'(settings.pressure_target)));
        ci = (w < 0) ? 0 : w / 100;
        if (ci > 10000)
            ci = 10000;
        if (ci >= longint'(settings.good_threshold))
            res.level = LEVEL_GOOD;
        else if (ci >= longint'(settings.moderate_threshold))
            res.level = LEVEL_MODERATE;
        else if (ci >= longint'(settings.poor_threshold))
            res.level = LEVEL_POOR;
        else
            res.level = LEVEL_CRITICAL;
        res.score               = ci[INDEX_W-1:0];
        res.average_temperature = at[TEMP_W-1:0];
        res.average_humidity    = ah[HUM_W-1:0];
        res.average_pressure    = ap[PRES_W-1:0];
        return 1'b1;
    endfunction

    function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = value;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void plan_sample(input logic [TEMP_W-1:0] t, input logic [HUM_W-1:0] h,
                                        input logic [PRES_W-1:0] p);
        plan_row_t r;
        r.kind        = ROW_SAMPLE;
        r.temperature = t;
        r.humidity    = h;
        r.pressure    = p;
        r.typed       = 1'b0;
        r.typed_gives = 1'b0;
        plan.insert(plan.size(), r);
    endfunction

    // Window holds only copies of this sample, so the averages are the sample itself.
    function automatic void plan_typed(input logic [TEMP_W-1:0] t, input logic [HUM_W-1:0] h,
                                       input logic [PRES_W-1:0] p, input bit gives,
                                       input logic [INDEX_W-1:0] ci, input level_t lvl);
        plan_row_t r;
        r.kind                     = ROW_SAMPLE;
        r.temperature              = t;
        r.humidity                 = h;
        r.pressure                 = p;
        r.typed                    = 1'b1;
        r.typed_gives              = gives;
        r.want.score               = ci;
        r.want.level               = lvl;
        r.want.average_temperature = t;
        r.want.average_humidity    = h;
        r.want.average_pressure    = p;
        plan.insert(plan.size(), r);
    endfunction

    function automatic plan_row_t random_row();
        plan_row_t r;
        int        sel, tv, hv, pv;
        sel = $urandom_range(0, 19);
        if (sel < 15)
        begin
            // Near the targets, so the index spreads over its whole range.
            tv = int'($signed(settings.temperature_target)) + int'($urandom_range(0, 3000)) - 1500;
            hv = int'(settings.humidity_target) + int'($urandom_range(0, 4000)) - 2000;
            pv = int'(settings.pressure_target) + int'($urandom_range(0, 100000)) - 50000;
        end
        else if (sel < 18)
        begin
            tv = int'($urandom_range(0, 16500)) - 4000;
            hv = $urandom_range(0, 10000);
            pv = $urandom_range(30000, 120000);
        end
        else
        begin
            tv = $urandom;
            hv = $urandom;
            pv = $urandom;
        end
        r.kind        = ROW_SAMPLE;
        r.temperature = tv[TEMP_W-1:0];
        r.humidity    = hv[HUM_W-1:0];
        r.pressure    = pv[PRES_W-1:0];
        r.typed       = 1'b0;
        r.typed_gives = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0d, want %0d",
                                      results_checked, name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_setting(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] g,
                             input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] pr);
        write_reg(CFG_TEMPERATURE_TARGET, t);
        write_reg(CFG_HUMIDITY_TARGET, h);
        write_reg(CFG_PRESSURE_TARGET, p);
        write_reg(CFG_GOOD_THRESHOLD, g);
        write_reg(CFG_MODERATE_THRESHOLD, m);
        write_reg(CFG_POOR_THRESHOLD, pr);
    endtask

    // Hold the input, wait for every expected word, then let the pipeline empty.
    task automatic settle();
        if (dirty)
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            dirty = 1'b0;
        end
    endtask

    task automatic send_sample(input plan_row_t row);
        int unsigned     gap;
        bit              gives;
        comfort_result_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({row.pressure, row.humidity, row.temperature});
        do @(posedge clk); while (!s_tready);
        gives = score_window(row.temperature, row.humidity, row.pressure, predicted);
        if (row.typed)
        begin
            gives     = row.typed_gives;
            predicted = row.want;
        end
        if (gives)
            pending_results.insert(pending_results.size(), predicted);
        samples_sent++;
        dirty = 1'b1;
    endtask

    task automatic load_phase(input int ph);
        case (ph)
            0: write_all(CFG_DATA_W'(2200), CFG_DATA_W'(5000), CFG_DATA_W'(101325),
                         CFG_DATA_W'(8000), CFG_DATA_W'(6000), CFG_DATA_W'(4000));
            1: write_all(CFG_DATA_W'(-4000), CFG_DATA_W'(0), CFG_DATA_W'(30000),
                         CFG_DATA_W'(10000), CFG_DATA_W'(10000), CFG_DATA_W'(10000));
            2: write_all(CFG_DATA_W'(12500), CFG_DATA_W'(10000), CFG_DATA_W'(120000),
                         CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(0));
            3: write_all(17'h1C000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1C000, 17'h00000);
            7: write_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                         CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            default: write_all(CFG_DATA_W'(int'($urandom_range(0, 16500)) - 4000),
                               CFG_DATA_W'($urandom_range(0, 10000)),
                               CFG_DATA_W'($urandom_range(30000, 120000)),
                               CFG_DATA_W'($urandom_range(0, 10000)),
                               CFG_DATA_W'($urandom_range(0, 10000)),
                               CFG_DATA_W'($urandom_range(0, 10000)));
        endcase
    endtask

    // Result side: random stalls, then compare each word with the oldest expectation.
    initial
    begin
        int unsigned           stall;
        logic [OUT_DATA_W-1:0] word;
        comfort_result_t       want;
        wait (rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            word = m_tdata;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("word %0d arrived with none expected: %h",
                                          results_checked, word));
            else
            begin
                want = pending_results.pop_front();
                check_field("score", 32'(word[INDEX_W-1:0]), 32'(want.score));
                check_field("level", 32'(word[LEVEL_LO +: LEVEL_W]),
                            32'(want.level));
                check_field("average_temperature", 32'(word[AVG_T_LO +: TEMP_W]),
                            32'(want.average_temperature));
                check_field("average_humidity", 32'(word[AVG_H_LO +: HUM_W]),
                            32'(want.average_humidity));
                check_field("average_pressure", 32'(word[AVG_P_LO +: PRES_W]),
                            32'(want.average_pressure));
            end
            results_checked++;
        end
    end

    // Watchdog: end the run when no word moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        plan_row_t row;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Fewer than three samples give nothing; then exact targets score the top.
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b0, '0, LEVEL_GOOD);
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b0, '0, LEVEL_GOOD);
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_GOOD);
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_GOOD);
        // Walk the level down one threshold at a time, then leave them unordered.
        plan_write(CFG_GOOD_THRESHOLD, CFG_DATA_W'(10001));
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_MODERATE);
        plan_write(CFG_MODERATE_THRESHOLD, CFG_DATA_W'(16383));
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_POOR);
        plan_write(CFG_POOR_THRESHOLD, CFG_DATA_W'(16383));
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_CRITICAL);
        plan_write(CFG_GOOD_THRESHOLD, CFG_DATA_W'(0));
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_GOOD);
        plan_write(CFG_SPARE_6, 17'h15555);
        plan_write(CFG_SPARE_7, 17'h0AAAA);
        plan_typed(TEMP_W'(2200), HUM_W'(5000), PRES_W'(101325), 1'b1, 10000, LEVEL_GOOD);
        plan_write(CFG_GOOD_THRESHOLD, CFG_DATA_W'(8000));
        plan_write(CFG_MODERATE_THRESHOLD, CFG_DATA_W'(6000));
        plan_write(CFG_POOR_THRESHOLD, CFG_DATA_W'(4000));
        // Range and full-width extremes; the window fills and starts to slide.
        plan_sample(TEMP_W'(12500), HUM_W'(10000), PRES_W'(120000));
        plan_sample(TEMP_W'(-4000), HUM_W'(0), PRES_W'(30000));
        plan_sample(15'h3FFF, 14'h3FFF, 17'h1FFFF);
        plan_sample(15'h4000, 14'h0000, 17'h00000);
        plan_sample(15'h4000, 14'h0000, 17'h00000);
        plan_sample(15'h2AAA, 14'h1555, 17'h0AAAA);
        plan_sample(15'h5555, 14'h2AAA, 17'h15555);
        plan_write(CFG_TEMPERATURE_TARGET, 17'h1C000);
        plan_write(CFG_PRESSURE_TARGET, 17'h1FFFF);
        plan_sample(15'h4000, 14'h3FFF, 17'h1FFFF);
        plan_sample(15'h4000, 14'h3FFF, 17'h1FFFF);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                settle();
                write_reg(row.reg_index, row.reg_value);
            end
            else
                send_sample(row);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            load_phase(ph);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Now and then run a stretch with no idling on either side.
                if (k % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_sample(random_row());
            end
        end
        no_gaps = 1'b0;
        settle();

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      pending_results.size()));
        $display("Covered %0d samples and %0d result words over %0d random settings",
                 samples_sent, results_checked, RANDOM_PHASES);
        $display("Directed rows hit every level, unordered and spare registers, field extremes");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/wacs_pkg.sv
hw/rtl/wacs_fifo.sv
hw/rtl/wacs_front.sv
hw/rtl/wacs_div.sv
hw/rtl/wacs_back.sv
hw/rtl/window_average_comfort_scorer.sv
tb/sv/window_average_comfort_scorer_tb.sv
